// ----- rtl/assert_macros.svh -----
// Assertion macros used by the output stage of the LED ring heading encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define LRHE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define LRHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LRHE_ASSERT(lbl, prop, msg)
`define LRHE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/lrhe_pkg.sv -----
// Types, constants and helper functions of the LED ring heading encoder.
package lrhe_pkg;

  localparam int RING_MAX = 64;
  localparam int MAX_LEDS = 256;

  localparam int ANGLE_W = 12;
  localparam int COLOR_W = 24;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 8;
  localparam int WORD_W  = 40;
  localparam int CHAN_W  = 2;
  localparam int SYM_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int RINGS   = 4;
  localparam int TOTAL_W = COUNT_W + 2;
  localparam int PROD_W  = ANGLE_W + COUNT_W;

  localparam int TURN_TENTHS = 3600;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(TURN_TENTHS - 1);

  // floor(p / 3600) == (p * RECIP) >> RECIP_SHIFT for every p below 2**PROD_W
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP = (2**RECIP_SHIFT + TURN_TENTHS - 1) / TURN_TENTHS;
  localparam int RECIP_W = 19;

  localparam logic [SYM_W-1:0] SYM_ONE  = 5'b11100;
  localparam logic [SYM_W-1:0] SYM_ZERO = 5'b10000;

  // Configuration register indexes
  localparam int REG_W = 3;
  localparam logic [REG_W-1:0] REG_ANGLE     = 3'd0;
  localparam logic [REG_W-1:0] REG_MARKER    = 3'd1;
  localparam logic [REG_W-1:0] REG_FILL      = 3'd2;
  localparam logic [REG_W-1:0] REG_OUTER     = 3'd3;
  localparam logic [REG_W-1:0] REG_MIDDLE    = 3'd4;
  localparam logic [REG_W-1:0] REG_MID_INNER = 3'd5;
  localparam logic [REG_W-1:0] REG_INNER     = 3'd6;

  typedef logic [CHAN_W-1:0] chan_t;
  localparam chan_t CH_GREEN = 2'd0;
  localparam chan_t CH_RED   = 2'd1;
  localparam chan_t CH_BLUE  = 2'd2;

  typedef logic [RINGS-1:0][COUNT_W-1:0] counts_t;

  // Ring lookup result of one LED index
  typedef struct packed {
    logic               in_chain;
    logic               mid_ring;
    logic [COUNT_W-1:0] off;
    logic [COUNT_W-1:0] cnt;
  } loc_t;

  // Ring lookup plus the marker offset of that ring
  typedef struct packed {
    loc_t               loc;
    logic [COUNT_W-1:0] tgt;
  } tgt_t;

  // Marker or fill color of one LED
  typedef struct packed {
    logic               in_chain;
    logic [COLOR_W-1:0] color;
  } pix_t;

  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    r = c;
    if (int'(c) > RING_MAX) begin
      r = COUNT_W'(RING_MAX);
    end
    return r;
  endfunction

  // Expand one byte, MSB first, into eight 5-bit line symbols
  function automatic logic [WORD_W-1:0] expand_byte(input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      w[SYM_W*i +: SYM_W] = b[i] ? SYM_ONE : SYM_ZERO;
    end
    return w;
  endfunction

endpackage

// ----- rtl/led_ring_heading_encoder.sv -----
// Top level of the LED ring heading encoder: config registers and pipeline.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_led_index[7:0]
//   out_     output     out_valid / out_stall out_symbol_word[39:0], out_channel[1:0], out_last
//   cfg_     input      cfg_valid / cfg_ready cfg_index[2:0], cfg_data[23:0]
//
// Each LED index yields three words (green, red, blue), one per cycle while
// out_stall is low; the output word stage takes the next index as the blue word leaves.
// Each index passes the locate, multiply, reciprocal scale, marker select and
// output word stage registers in that order before its first word appears.
// Stalls propagate back stage by stage; stages with no item keep accepting.
// Synchronous active-low reset empties the pipeline and loads the default
// ring counts 60, 48, 40, 32; cfg_ready is always high.
module led_ring_heading_encoder
  import lrhe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [INDEX_W-1:0] in_led_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [WORD_W-1:0]  out_symbol_word,
  output logic [CHAN_W-1:0]  out_channel,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [REG_W-1:0]   cfg_index,
  input  logic [COLOR_W-1:0] cfg_data
);

  logic [ANGLE_W-1:0] angle_r;
  logic [COLOR_W-1:0] marker_r;
  logic [COLOR_W-1:0] fill_r;
  counts_t            counts_r;

  logic loc_ready;
  logic loc_valid;
  loc_t loc;
  logic tgt_ready;
  logic tgt_valid;
  tgt_t tgt;
  logic pix_ready;
  logic pix_valid;
  pix_t pix;
  chan_t chan;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r     <= '0;
      marker_r    <= '0;
      fill_r      <= '0;
      counts_r[0] <= COUNT_W'(60);
      counts_r[1] <= COUNT_W'(48);
      counts_r[2] <= COUNT_W'(40);
      counts_r[3] <= COUNT_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ANGLE:     angle_r     <= cfg_data[ANGLE_W-1:0];
        REG_MARKER:    marker_r    <= cfg_data;
        REG_FILL:      fill_r      <= cfg_data;
        REG_OUTER:     counts_r[0] <= cfg_data[COUNT_W-1:0];
        REG_MIDDLE:    counts_r[1] <= cfg_data[COUNT_W-1:0];
        REG_MID_INNER: counts_r[2] <= cfg_data[COUNT_W-1:0];
        REG_INNER:     counts_r[3] <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = !loc_ready;

  lrhe_locate u_locate (
    .clk        (clk),
    .rst_n      (rst_n),
    .counts     (counts_r),
    .up_valid   (in_valid),
    .up_ready   (loc_ready),
    .up_index   (in_led_index),
    .down_valid (loc_valid),
    .down_ready (tgt_ready),
    .down_loc   (loc)
  );

  lrhe_target u_target (
    .clk        (clk),
    .rst_n      (rst_n),
    .angle      (angle_r),
    .up_valid   (loc_valid),
    .up_ready   (tgt_ready),
    .up_loc     (loc),
    .down_valid (tgt_valid),
    .down_ready (pix_ready),
    .down_tgt   (tgt)
  );

  logic mark_ready;

  lrhe_mark u_mark (
    .clk          (clk),
    .rst_n        (rst_n),
    .marker_color (marker_r),
    .fill_color   (fill_r),
    .up_valid     (tgt_valid),
    .up_ready     (pix_ready),
    .up_tgt       (tgt),
    .down_valid   (pix_valid),
    .down_ready   (mark_ready),
    .down_pix     (pix)
  );

  lrhe_serial u_serial (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (pix_valid),
    .up_ready        (mark_ready),
    .up_pix          (pix),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol_word (out_symbol_word),
    .out_channel     (chan),
    .out_last        (out_last)
  );

  assign out_channel = chan;

endmodule

// ----- rtl/lrhe_locate.sv -----
// Stage one: find the ring, offset and clamped count of an LED index.
module lrhe_locate
  import lrhe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  counts_t            counts,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic [INDEX_W-1:0] up_index,
  output logic               down_valid,
  input  logic               down_ready,
  output loc_t               down_loc
);

  logic               v_r;
  loc_t               loc_r;
  loc_t               loc_nxt;
  counts_t            cl;
  logic [TOTAL_W-1:0] b1;
  logic [TOTAL_W-1:0] b2;
  logic [TOTAL_W-1:0] b3;
  logic [TOTAL_W-1:0] sum;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] idx;
  logic [TOTAL_W-1:0] base;

  always_comb begin
    for (int r = 0; r < RINGS; r++) begin
      cl[r] = clamp_count(counts[r]);
    end
    idx = TOTAL_W'(up_index);
    b1  = TOTAL_W'(cl[0]);
    b2  = b1 + TOTAL_W'(cl[1]);
    b3  = b2 + TOTAL_W'(cl[2]);
    sum = b3 + TOTAL_W'(cl[3]);
    total = (int'(sum) > MAX_LEDS) ? TOTAL_W'(MAX_LEDS) : sum;

    loc_nxt.in_chain = idx < total;
    loc_nxt.mid_ring = 1'b0;
    // an empty ring never wins for an index in the chain: its range is empty and the index falls to a later ring
    priority if (idx < b1) begin
      base        = '0;
      loc_nxt.cnt = cl[0];
    end else if (idx < b2) begin
      base             = b1;
      loc_nxt.cnt      = cl[1];
      loc_nxt.mid_ring = 1'b1;
    end else if (idx < b3) begin
      base        = b2;
      loc_nxt.cnt = cl[2];
    end else begin
      base        = b3;
      loc_nxt.cnt = cl[3];
    end
    loc_nxt.off = COUNT_W'(idx - base);
  end

  assign up_ready   = !v_r || down_ready;
  assign down_valid = v_r;
  assign down_loc   = loc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      loc_r <= loc_nxt;
    end
  end

endmodule

// ----- rtl/lrhe_target.sv -----
// Stages two and three: marker offset floor(angle * count / 3600) of the ring, angle capped at 3599.
module lrhe_target
  import lrhe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ANGLE_W-1:0] angle,
  input  logic               up_valid,
  output logic               up_ready,
  input  loc_t               up_loc,
  output logic               down_valid,
  input  logic               down_ready,
  output tgt_t               down_tgt
);

  logic                      prod_v_r;
  loc_t                      prod_loc_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      q_v_r;
  tgt_t                      q_r;
  logic                      prod_ready;
  logic [ANGLE_W-1:0]        a_sat;
  logic [PROD_W+RECIP_W-1:0] scaled;

  assign a_sat  = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
  assign scaled = (PROD_W+RECIP_W)'(prod_r) * (PROD_W+RECIP_W)'(RECIP);

  assign prod_ready = !q_v_r || down_ready;
  assign up_ready   = !prod_v_r || prod_ready;
  assign down_valid = q_v_r;
  assign down_tgt   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      q_v_r    <= 1'b0;
    end else begin
      if (up_ready) begin
        prod_v_r <= up_valid;
      end
      if (prod_ready) begin
        q_v_r <= prod_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_loc_r <= up_loc;
      prod_r     <= PROD_W'(a_sat) * PROD_W'(up_loc.cnt);
    end
    if (prod_ready && prod_v_r) begin
      q_r.loc <= prod_loc_r;
      q_r.tgt <= scaled[RECIP_SHIFT +: COUNT_W];
    end
  end

endmodule

// ----- rtl/lrhe_mark.sv -----
// Stage four: marker decision with middle ring neighbors, and color choice.
module lrhe_mark
  import lrhe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COLOR_W-1:0] marker_color,
  input  logic [COLOR_W-1:0] fill_color,
  input  logic               up_valid,
  output logic               up_ready,
  input  tgt_t               up_tgt,
  output logic               down_valid,
  input  logic               down_ready,
  output pix_t               down_pix
);

  logic               v_r;
  pix_t               pix_r;
  logic [COUNT_W-1:0] prev_off;
  logic [COUNT_W-1:0] next_off;
  logic               marker;

  always_comb begin
    // wrap the neighbors around the ring; the target is below the count of any non-empty ring
    prev_off = (up_tgt.tgt == '0) ? up_tgt.loc.cnt - COUNT_W'(1)
                                  : up_tgt.tgt - COUNT_W'(1);
    next_off = (up_tgt.tgt + COUNT_W'(1) == up_tgt.loc.cnt) ? '0
                                                             : up_tgt.tgt + COUNT_W'(1);
    marker = up_tgt.loc.in_chain &&
             ((up_tgt.loc.off == up_tgt.tgt) ||
              (up_tgt.loc.mid_ring &&
               ((up_tgt.loc.off == prev_off) || (up_tgt.loc.off == next_off))));
  end

  assign up_ready   = !v_r || down_ready;
  assign down_valid = v_r;
  assign down_pix   = pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pix_r.in_chain <= up_tgt.loc.in_chain;
      pix_r.color    <= marker ? marker_color : fill_color;
    end
  end

endmodule

// ----- rtl/lrhe_serial.sv -----
// Output stage: send one color as green, red and blue symbol words.
`include "assert_macros.svh"
module lrhe_serial
  import lrhe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  pix_t              up_pix,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_symbol_word,
  output chan_t             out_channel,
  output logic              out_last
);

  logic              ser_v_r;
  chan_t             ch_r;
  pix_t              pix_r;
  logic              accept;
  logic              done;
  logic [BYTE_W-1:0] sel_byte;

  assign accept   = ser_v_r && !out_stall;
  assign done     = accept && (ch_r == CH_BLUE);
  assign up_ready = !ser_v_r || done;

  always_comb begin
    unique case (ch_r)
      CH_GREEN: sel_byte = pix_r.color[15:8];
      CH_RED:   sel_byte = pix_r.color[23:16];
      CH_BLUE:  sel_byte = pix_r.color[7:0];
      default:  sel_byte = '0;
    endcase
  end

  // past the end of the chain: send latch symbols
  assign out_symbol_word = pix_r.in_chain ? expand_byte(sel_byte) : '0;
  assign out_channel     = ch_r;
  assign out_last        = (ch_r == CH_BLUE);
  assign out_valid       = ser_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      ch_r    <= CH_GREEN;
    end else begin
      if (up_ready) begin
        ser_v_r <= up_valid;
      end
      if (done) begin
        ch_r <= CH_GREEN;
      end else if (accept) begin
        ch_r <= ch_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pix_r <= up_pix;
    end
  end

  `LRHE_ASSERT(a_idle_green, !ser_v_r |-> (ch_r == CH_GREEN), "word counter moved while empty")
  `LRHE_ASSERT_NEXT(a_word_step, accept && (ch_r != CH_BLUE), ser_v_r && (ch_r == $past(ch_r) + 2'd1), "word not advanced")
  `LRHE_ASSERT_NEXT(a_retire, done && !up_valid, !ser_v_r && (ch_r == CH_GREEN), "item not retired after blue word")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the LED ring heading encoder: registers, marker choice, symbols.
`timescale 1ns / 100ps

typedef struct packed {
  logic [lrhe_pkg::WORD_W-1:0] word;
  lrhe_pkg::chan_t             chan;
  logic                        last;
} grb_word_t;

class grb_word_board;
  logic [lrhe_pkg::ANGLE_W-1:0] angle_reg;
  logic [lrhe_pkg::COLOR_W-1:0] marker_reg;
  logic [lrhe_pkg::COLOR_W-1:0] fill_reg;
  logic [lrhe_pkg::COUNT_W-1:0] ring_reg[4];
  grb_word_t                    pending_words[$];
  int                           mismatches;

  function new();
    angle_reg   = '0;
    marker_reg  = '0;
    fill_reg    = '0;
    ring_reg[0] = 7'd60;
    ring_reg[1] = 7'd48;
    ring_reg[2] = 7'd40;
    ring_reg[3] = 7'd32;
    mismatches  = 0;
  endfunction

  function void write_reg(logic [lrhe_pkg::REG_W-1:0] idx, logic [lrhe_pkg::COLOR_W-1:0] data);
    case (idx)
      lrhe_pkg::REG_ANGLE:     angle_reg   = data[lrhe_pkg::ANGLE_W-1:0];
      lrhe_pkg::REG_MARKER:    marker_reg  = data;
      lrhe_pkg::REG_FILL:      fill_reg    = data;
      lrhe_pkg::REG_OUTER:     ring_reg[0] = data[lrhe_pkg::COUNT_W-1:0];
      lrhe_pkg::REG_MIDDLE:    ring_reg[1] = data[lrhe_pkg::COUNT_W-1:0];
      lrhe_pkg::REG_MID_INNER: ring_reg[2] = data[lrhe_pkg::COUNT_W-1:0];
      lrhe_pkg::REG_INNER:     ring_reg[3] = data[lrhe_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  function int ring_size(int r);
    return (int'(ring_reg[r]) > lrhe_pkg::RING_MAX) ? lrhe_pkg::RING_MAX : int'(ring_reg[r]);
  endfunction

  function int heading_tenths();
    return (int'(angle_reg) > lrhe_pkg::TURN_TENTHS - 1) ? lrhe_pkg::TURN_TENTHS - 1
                                                         : int'(angle_reg);
  endfunction

  function int chain_length();
    int sum;
    sum = 0;
    for (int r = 0; r < 4; r++) sum += ring_size(r);
    return (sum > lrhe_pkg::MAX_LEDS) ? lrhe_pkg::MAX_LEDS : sum;
  endfunction

  // Marker test: the heading LED of each ring, plus its two middle-ring neighbors
  function bit heading_led(int idx);
    int base, c, off, tgt;
    base = 0;
    for (int r = 0; r < 4; r++) begin
      c = ring_size(r);
      if (c != 0 && idx >= base && idx < base + c) begin
        off = idx - base;
        tgt = (heading_tenths() * c) / lrhe_pkg::TURN_TENTHS;
        if (off == tgt) return 1'b1;
        if (r == 1 && (off == (tgt + c - 1) % c || off == (tgt + 1) % c)) return 1'b1;
        return 1'b0;
      end
      base += c;
    end
    return 1'b0;
  endfunction

  function logic [lrhe_pkg::WORD_W-1:0] line_symbols(logic [7:0] b);
    logic [lrhe_pkg::WORD_W-1:0] w;
    w = '0;
    for (int i = 7; i >= 0; i--) begin
      w = {w[lrhe_pkg::WORD_W-lrhe_pkg::SYM_W-1:0],
           b[i] ? lrhe_pkg::SYM_ONE : lrhe_pkg::SYM_ZERO};
    end
    return w;
  endfunction

  // Aim at a marker or one of its neighbors in a random ring
  function logic [7:0] pick_near_marker();
    int r, base, c, tgt;
    r = $urandom_range(0, 3);
    base = 0;
    for (int k = 0; k < r; k++) base += ring_size(k);
    c = ring_size(r);
    if (c == 0) return 8'($urandom_range(0, 255));
    tgt = (heading_tenths() * c) / lrhe_pkg::TURN_TENTHS;
    return 8'(base + (tgt + c + $urandom_range(0, 2) - 1) % c);
  endfunction

  function void note_request(logic [7:0] idx);
    logic [lrhe_pkg::COLOR_W-1:0] color;
    logic [7:0]                   chan_byte;
    lrhe_pkg::chan_t              order[3];
    bit                           lit;
    grb_word_t                    w;
    order = '{lrhe_pkg::CH_GREEN, lrhe_pkg::CH_RED, lrhe_pkg::CH_BLUE};
    lit   = int'(idx) < chain_length();
    color = (lit && heading_led(int'(idx))) ? marker_reg : fill_reg;
    for (int k = 0; k < 3; k++) begin
      case (order[k])
        lrhe_pkg::CH_GREEN: chan_byte = color[15:8];
        lrhe_pkg::CH_RED:   chan_byte = color[23:16];
        default:            chan_byte = color[7:0];
      endcase
      w.word = lit ? line_symbols(chan_byte) : '0;
      w.chan = order[k];
      w.last = (order[k] == lrhe_pkg::CH_BLUE);
      pending_words.push_back(w);
    end
  endfunction

  function void flag_word(string what, grb_word_t e, grb_word_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected word %h channel %0d last %b, got word %h channel %0d last %b",
               $realtime, what, e.word, e.chan, e.last, got.word, got.chan, got.last);
    end
  endfunction

  function void check_word(logic [lrhe_pkg::WORD_W-1:0] word, lrhe_pkg::chan_t chan,
                           logic last);
    grb_word_t e, got;
    got.word = word;
    got.chan = chan;
    got.last = last;
    if (pending_words.size() == 0) begin
      e = '0;
      flag_word("word with no request pending", e, got);
      return;
    end
    e = pending_words.pop_front();
    if (e.word !== word || e.chan !== chan || e.last !== last) begin
      flag_word("word mismatch", e, got);
    end
  endfunction

  function int pending();
    return pending_words.size();
  endfunction
endclass

module testbench;
  import lrhe_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_ITEMS    = 62;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [INDEX_W-1:0] in_led_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [WORD_W-1:0]  out_symbol_word;
  logic [CHAN_W-1:0]  out_channel;
  logic               out_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [REG_W-1:0]   cfg_index = '0;
  logic [COLOR_W-1:0] cfg_data = '0;

  grb_word_board sb;
  bit            idling_on = 1'b1;
  int            stall_left = 0;
  int            quiet_cycles = 0;

  led_ring_heading_encoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_led_index    (in_led_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol_word (out_symbol_word),
    .out_channel     (out_channel),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Check every word taken, then decide the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_word(out_symbol_word, out_channel, out_last);
    end
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 11) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [COLOR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(input logic [COLOR_W-1:0] angle_d, input logic [COLOR_W-1:0] marker_d,
                                input logic [COLOR_W-1:0] fill_d, input logic [COLOR_W-1:0] c0,
                                input logic [COLOR_W-1:0] c1, input logic [COLOR_W-1:0] c2,
                                input logic [COLOR_W-1:0] c3);
    write_reg(REG_ANGLE, angle_d);
    write_reg(REG_MARKER, marker_d);
    write_reg(REG_FILL, fill_d);
    write_reg(REG_OUTER, c0);
    write_reg(REG_MIDDLE, c1);
    write_reg(REG_MID_INNER, c2);
    write_reg(REG_INNER, c3);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_led(input logic [INDEX_W-1:0] idx);
    in_valid     <= 1'b1;
    in_led_index <= idx;
    do @(posedge clk); while (in_stall);
    sb.note_request(idx);
  endtask

  // Hold until every word owed has come, then let the pipeline settle
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_list(input logic [INDEX_W-1:0] list[$]);
    foreach (list[i]) send_led(list[i]);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  task automatic run_random_items(input int n);
    logic [INDEX_W-1:0] idx;
    int                 span, pick;
    for (int i = 0; i < n; i++) begin
      span = sb.chain_length();
      pick = $urandom_range(0, 9);
      if (pick < 2 || span == 0) begin
        idx = INDEX_W'($urandom_range(0, 255));
      end else if (pick < 5) begin
        idx = sb.pick_near_marker();
      end else begin
        idx = INDEX_W'($urandom_range(0, span - 1));
      end
      if (i == n / 2 || $urandom_range(0, 49) == 0) begin
        in_valid <= 1'b0;
        wait_drained();
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      send_led(idx);
    end
    in_valid <= 1'b0;
  endtask

  function automatic logic [COLOR_W-1:0] rand_angle();
    logic [ANGLE_W-1:0] a;
    case ($urandom_range(0, 7))
      0:       a = '0;
      1:       a = ANGLE_MAX;
      2:       a = ANGLE_W'($urandom_range(3600, 4095));
      default: a = ANGLE_W'($urandom_range(0, 3599));
    endcase
    return {($urandom_range(0, 1) != 0) ? 12'($urandom) : 12'd0, a};
  endfunction

  function automatic logic [COLOR_W-1:0] rand_color();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] rand_count();
    logic [COUNT_W-1:0] c;
    case ($urandom_range(0, 9))
      0:       c = '0;
      1:       c = COUNT_W'($urandom_range(1, 2));
      2:       c = COUNT_W'(RING_MAX);
      3:       c = COUNT_W'($urandom_range(65, 127));
      default: c = COUNT_W'($urandom_range(1, 64));
    endcase
    return {($urandom_range(0, 1) != 0) ? 17'($urandom) : 17'd0, c};
  endfunction

  initial begin
    logic [COLOR_W-1:0] cnt[4];
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: black marker and fill, rings of 60, 48, 40, 32
    send_list('{8'd0, 8'd179, 8'd180, 8'd255});

    // Heading zero: marker at the start of each ring, middle neighbors wrap back
    apply_settings(24'd0, 24'hA5C33C, 24'h5A3CC3, 24'd60, 24'd48, 24'd40, 24'd32);
    send_list('{8'd0, 8'd1, 8'd60, 8'd61, 8'd62, 8'd106, 8'd107, 8'd148, 8'd179, 8'd180});

    // Largest heading, with junk above the angle field
    apply_settings(24'hFFFE0F, 24'h5A3CC3, 24'hA5C33C, 24'd60, 24'd48, 24'd40, 24'd32);
    send_list('{8'd59, 8'd60, 8'd106, 8'd107, 8'd147, 8'd179});

    // Angle past a full turn, oversized outer ring, two-LED middle, empty third ring
    apply_settings(24'd4095, 24'hFFFFFF, 24'h000000, 24'd127, 24'd2, 24'd0, 24'd64);
    send_list('{8'd63, 8'd64, 8'd65, 8'd66, 8'd129, 8'd130});

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      foreach (cnt[r]) cnt[r] = rand_count();
      if (p == 0) begin
        cnt = '{24'd64, 24'd1, 24'd0, 24'd127};
      end else if (p == 1) begin
        cnt = '{24'd3, 24'd0, 24'd64, 24'd65};
      end else if (p == RANDOM_PHASES - 1) begin
        cnt = '{24'd64, 24'd64, 24'd64, 24'd64};
        idling_on = 1'b0;
      end
      apply_settings(rand_angle(), rand_color(), rand_color(), cnt[0], cnt[1], cnt[2], cnt[3]);
      run_random_items(PHASE_ITEMS);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ----- led_ring_heading_encoder.f -----
+incdir+rtl
rtl/lrhe_pkg.sv
rtl/lrhe_locate.sv
rtl/lrhe_target.sv
rtl/lrhe_mark.sv
rtl/lrhe_serial.sv
rtl/led_ring_heading_encoder.sv
verif/testbench.sv
